### src/bdlp_pkg.sv
// Shared types and constants for the button debouncer with long-press detection.
// No dependencies; used by every module under src.
`timescale 1ns / 1ps

package bdlp_pkg;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam int POLL_W     = 10;
  localparam int DEB_W      = 10;
  localparam int LONG_W     = 16;

  localparam logic [CFG_IDX_W-1:0] REG_PRESS_LEVEL = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POLL_TICKS  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEB_TICKS   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_TICKS  = 8'd3;

  localparam logic              RST_PRESS_LEVEL = 1'b0;
  localparam logic [POLL_W-1:0] RST_POLL_TICKS  = 10'd20;
  localparam logic [DEB_W-1:0]  RST_DEB_TICKS   = 10'd50;
  localparam logic [LONG_W-1:0] RST_LONG_TICKS  = 16'd0;

  localparam logic [POLL_W-1:0] POLL_MAX = {POLL_W{1'b1}};

  typedef enum logic [1:0] {
    EV_PRESS   = 2'd0,
    EV_RELEASE = 2'd1,
    EV_LONG    = 2'd2
  } ev_kind_t;

  typedef struct packed {
    logic              press_level;
    logic [POLL_W-1:0] poll_ticks;
    logic [DEB_W-1:0]  deb_ticks;
    logic [LONG_W-1:0] long_ticks;
  } cfg_t;

  typedef struct packed {
    logic     valid;
    ev_kind_t kind;
    logic     pressed;
  } step_res_t;

endpackage

### src/bdlp_cfg.sv
// Configuration register file: four registers written over the cfg channel.
// Depends on bdlp_pkg for the register indexes, reset values and cfg_t.
`timescale 1ns / 1ps

module bdlp_cfg
  import bdlp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        REG_PRESS_LEVEL: cfg_nxt.press_level = wr_data[0];
        REG_POLL_TICKS:  cfg_nxt.poll_ticks  = wr_data[POLL_W-1:0];
        REG_DEB_TICKS:   cfg_nxt.deb_ticks   = wr_data[DEB_W-1:0];
        REG_LONG_TICKS:  cfg_nxt.long_ticks  = wr_data[LONG_W-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.press_level <= RST_PRESS_LEVEL;
      cfg_r.poll_ticks  <= RST_POLL_TICKS;
      cfg_r.deb_ticks   <= RST_DEB_TICKS;
      cfg_r.long_ticks  <= RST_LONG_TICKS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### src/bdlp_step.sv
// Debounce and long-press state with its per-tick update logic.
// Depends on bdlp_pkg for cfg_t, step_res_t and the event codes.
`timescale 1ns / 1ps

module bdlp_step
  import bdlp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      fire,
  input  logic      raw_level,
  input  cfg_t      cfg,
  output step_res_t res
);

  logic              primed_r,  primed_nxt;
  logic              stable_r,  stable_nxt;
  logic              deb_on_r,  deb_on_nxt;
  logic [POLL_W-1:0] poll_cnt_r, poll_cnt_nxt;
  logic [DEB_W-1:0]  deb_cnt_r,  deb_cnt_nxt;
  logic [LONG_W-1:0] long_cnt_r, long_cnt_nxt;
  logic              long_run_r, long_run_nxt;

  logic              level;
  logic              expired;
  logic              changed;
  logic [POLL_W-1:0] poll_inc;
  logic [POLL_W-1:0] interval;

  assign level    = (raw_level == cfg.press_level);
  assign poll_inc = (poll_cnt_r == POLL_MAX) ? poll_cnt_r : poll_cnt_r + 1'b1;
  assign interval = (cfg.poll_ticks == '0) ? POLL_W'(1) : cfg.poll_ticks;

  always_comb begin
    primed_nxt   = primed_r;
    stable_nxt   = stable_r;
    deb_on_nxt   = deb_on_r;
    poll_cnt_nxt = poll_cnt_r;
    deb_cnt_nxt  = deb_cnt_r;
    long_cnt_nxt = long_cnt_r;
    long_run_nxt = long_run_r;
    expired      = 1'b0;
    changed      = 1'b0;
    res.valid    = 1'b0;
    res.kind     = EV_PRESS;

    if (!primed_r) begin
      // first tick only loads the stable state
      primed_nxt   = 1'b1;
      stable_nxt   = level;
      deb_on_nxt   = 1'b0;
      poll_cnt_nxt = '0;
      deb_cnt_nxt  = '0;
    end else begin
      if (long_run_r) begin
        if (long_cnt_r <= LONG_W'(1)) begin
          long_run_nxt = 1'b0;
          long_cnt_nxt = '0;
          expired      = 1'b1;
        end else begin
          long_cnt_nxt = long_cnt_r - 1'b1;
        end
      end

      if (deb_on_r) begin
        if (deb_cnt_r <= DEB_W'(1)) begin
          deb_on_nxt   = 1'b0;
          deb_cnt_nxt  = '0;
          poll_cnt_nxt = '0;
          changed      = (level != stable_r);
        end else begin
          deb_cnt_nxt = deb_cnt_r - 1'b1;
        end
      end else if (poll_inc >= interval) begin
        poll_cnt_nxt = '0;
        if (level != stable_r) begin
          if (cfg.deb_ticks == '0) begin
            changed = 1'b1;
          end else begin
            deb_on_nxt  = 1'b1;
            deb_cnt_nxt = cfg.deb_ticks;
          end
        end
      end else begin
        poll_cnt_nxt = poll_inc;
      end

      if (changed) begin
        stable_nxt = level;
        res.valid  = 1'b1;
        if (level) begin
          res.kind = EV_PRESS;
          if (cfg.long_ticks != '0) begin
            long_run_nxt = 1'b1;
            long_cnt_nxt = cfg.long_ticks;
          end
        end else begin
          // release wins over an expiry on the same tick
          res.kind     = EV_RELEASE;
          long_run_nxt = 1'b0;
          long_cnt_nxt = '0;
        end
      end else if (expired && stable_r) begin
        res.valid = 1'b1;
        res.kind  = EV_LONG;
      end
    end

    res.pressed = stable_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      primed_r   <= 1'b0;
      stable_r   <= 1'b0;
      deb_on_r   <= 1'b0;
      poll_cnt_r <= '0;
      deb_cnt_r  <= '0;
      long_cnt_r <= '0;
      long_run_r <= 1'b0;
    end else if (fire) begin
      primed_r   <= primed_nxt;
      stable_r   <= stable_nxt;
      deb_on_r   <= deb_on_nxt;
      poll_cnt_r <= poll_cnt_nxt;
      deb_cnt_r  <= deb_cnt_nxt;
      long_cnt_r <= long_cnt_nxt;
      long_run_r <= long_run_nxt;
    end
  end

endmodule

### src/button_debounce_long_press.sv
// Button debouncer with long-press detection for one button. Each input word is one
// tick of the time base carrying the raw pin level; the block takes one word per
// clock cycle, and a result (press, release or long press) passes from the input
// register through the single state-update stage into the output register. The
// stage stalls only while an unaccepted result holds the output register, and the
// input register then keeps its word. Ticks that cause no event give no word.
// Depends on bdlp_pkg, bdlp_cfg and bdlp_step.
`timescale 1ns / 1ps

module button_debounce_long_press
  import bdlp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [0] raw_level, [7:1] zero
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [7:0]            out_tdata,  // [0] pressed_now, [7:1] zero
  output logic [1:0]            out_tuser,  // [1:0] event_kind
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t      cfg;
  step_res_t res;

  logic     in_valid_r, in_valid_nxt;
  logic     in_level_r;
  logic     out_valid_r, out_valid_nxt;
  ev_kind_t out_kind_r;
  logic     out_pressed_r;
  logic     step_fire;

  assign cfg_ready = 1'b1;

  bdlp_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  bdlp_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (step_fire),
    .raw_level (in_level_r),
    .cfg       (cfg),
    .res       (res)
  );

  // advance the held word only when the output register can take a result
  assign step_fire = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || step_fire;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_tvalid && in_tready) begin
      in_valid_nxt = 1'b1;
    end else if (step_fire) begin
      in_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (step_fire) begin
      out_valid_nxt = res.valid;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_level_r <= in_tdata[0];
    end
    if (step_fire && res.valid) begin
      out_kind_r    <= res.kind;
      out_pressed_r <= res.pressed;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_pressed_r};
  assign out_tuser  = out_kind_r;

endmodule
